// ----- hdl/tsr_pkg.sv -----
package tsr_pkg;

  // Defaults for the top-level parameters.
  localparam int WINDOW_DEF     = 64;
  localparam int INDEX_BITS_DEF = 32;

  // Window-size register.
  localparam int             WIN_REG_W = 7;
  localparam logic [6:0]     WIN_RESET = 7'd64;

  // Depth of the command queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    DISP_DELIVERED = 3'd0,
    DISP_BUFFERED  = 3'd1,
    DISP_DUPLICATE = 3'd2,
    DISP_OUTSIDE   = 3'd3,
    DISP_AFTER_END = 3'd4
  } disp_t;

  typedef enum logic [1:0] {
    CMD_DELIVER = 2'd0,
    CMD_STORE   = 2'd1,
    CMD_DROP    = 2'd2
  } cmd_kind_t;

  typedef enum logic [2:0] {
    B_IDLE     = 3'd0,
    B_SCAN     = 3'd1,
    B_COMMIT   = 3'd2,
    B_EMIT_ONE = 3'd3,
    B_EMIT_RUN = 3'd4
  } back_state_t;

  typedef struct packed {
    logic [31:0] stream_index;
    logic [7:0]  data_byte;
    logic        final_byte;
  } item_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [31:0] out_position;
    logic        stream_ended;
    logic [2:0]  disposition;
    logic [6:0]  pending_count;
    logic [31:0] next_expected;
    logic        last_of_run;
  } result_t;

  // Classified command handed from the front to the back end. The store
  // slot travels next to it in the queue, since its width follows WINDOW.
  typedef struct packed {
    cmd_kind_t  kind;
    disp_t      disp;
    logic [7:0] data_byte;
    logic       final_byte;
  } cmd_t;

endpackage

// ----- hdl/tsr_cmd_queue.sv -----
module tsr_cmd_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = tsr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign do_push    = push && (fill != CNT_W'(DEPTH));
  assign do_pop     = pop && (fill != '0);
  assign head_valid = (fill != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    push |-> (fill != CNT_W'(DEPTH)))
    else $error("command pushed into a full queue");

endmodule

// ----- hdl/tsr_front.sv -----
module tsr_front #(
  parameter int WINDOW     = tsr_pkg::WINDOW_DEF,
  parameter int INDEX_BITS = tsr_pkg::INDEX_BITS_DEF,
  parameter int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  tsr_pkg::item_t        item,
  input  logic                  cfg_write,
  input  logic [6:0]            cfg_data,
  input  logic [INDEX_BITS-1:0] exp_pos,
  input  logic [SLOT_W-1:0]     head,
  input  logic                  ended,
  input  logic                  back_idle,
  input  logic                  q_valid,
  output logic                  push,
  output tsr_pkg::cmd_t         push_cmd,
  output logic [SLOT_W-1:0]     push_slot
);

  import tsr_pkg::*;

  logic                  hold_valid;
  item_t                 hold;
  logic [6:0]            win_reg;
  logic [INDEX_BITS-1:0] idx;
  logic [INDEX_BITS-1:0] offset;
  logic [INDEX_BITS-1:0] win_ext;
  logic [INDEX_BITS-1:0] win_eff;
  logic [SLOT_W:0]       slot_sum;
  logic                  issue;

  // Classification needs the state that the back end leaves behind, so an
  // item is classified only once all earlier work has been carried out.
  assign issue      = hold_valid && !q_valid && back_idle;
  assign item_stall = hold_valid && !issue;
  assign push       = issue;

  assign idx     = INDEX_BITS'(hold.stream_index);
  assign offset  = idx - exp_pos;
  assign win_ext = INDEX_BITS'(win_reg);

  always_comb begin
    if (win_reg == '0) begin
      win_eff = INDEX_BITS'(1);
    end else if (win_ext > INDEX_BITS'(WINDOW)) begin
      win_eff = INDEX_BITS'(WINDOW);
    end else begin
      win_eff = win_ext;
    end
  end

  assign slot_sum  = (SLOT_W + 1)'(head) + (SLOT_W + 1)'(offset[SLOT_W-1:0]);
  assign push_slot = (slot_sum >= (SLOT_W + 1)'(WINDOW)) ?
                     SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW)) : SLOT_W'(slot_sum);

  always_comb begin
    push_cmd.data_byte  = hold.data_byte;
    push_cmd.final_byte = hold.final_byte;
    push_cmd.kind       = CMD_DROP;
    push_cmd.disp       = DISP_AFTER_END;
    priority if (ended) begin
      push_cmd.kind = CMD_DROP;
      push_cmd.disp = DISP_AFTER_END;
    end else if (offset == '0) begin
      push_cmd.kind = CMD_DELIVER;
      push_cmd.disp = DISP_DELIVERED;
    end else if (offset[INDEX_BITS-1]) begin
      push_cmd.kind = CMD_DROP;
      push_cmd.disp = DISP_DUPLICATE;
    end else if (offset >= win_eff) begin
      push_cmd.kind = CMD_DROP;
      push_cmd.disp = DISP_OUTSIDE;
    end else begin
      push_cmd.kind = CMD_STORE;
      push_cmd.disp = DISP_BUFFERED;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      hold <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      win_reg    <= WIN_RESET;
    end else begin
      if (item_valid && !item_stall) begin
        hold_valid <= 1'b1;
      end else if (issue) begin
        hold_valid <= 1'b0;
      end
      if (cfg_write) begin
        win_reg <= cfg_data;
      end
    end
  end

endmodule

// ----- hdl/tsr_back.sv -----
module tsr_back #(
  parameter int WINDOW     = tsr_pkg::WINDOW_DEF,
  parameter int INDEX_BITS = tsr_pkg::INDEX_BITS_DEF,
  parameter int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  tsr_pkg::cmd_t         q_cmd,
  input  logic [SLOT_W-1:0]     q_slot,
  output logic                  q_pop,
  output logic [INDEX_BITS-1:0] exp_pos,
  output logic [SLOT_W-1:0]     head,
  output logic                  ended,
  output logic                  idle,
  output logic                  result_valid,
  input  logic                  result_stall,
  output tsr_pkg::result_t      result
);

  import tsr_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [SLOT_W-1:0] RUN_MAX   = SLOT_W'(WINDOW - 1);

  back_state_t state;
  back_state_t state_next;

  logic [INDEX_BITS-1:0] expected;
  logic [SLOT_W-1:0]     count;
  logic                  ended_flag;
  logic [WINDOW-1:0]     present;
  logic [WINDOW-1:0]     final_mark;
  logic [7:0]            held_mem [WINDOW];

  logic [7:0]            cmd_byte;
  disp_t                 disp_r;
  logic [SLOT_W-1:0]     run_len;
  logic                  end_pend;
  logic [SLOT_W-1:0]     scan_slot;
  logic [SLOT_W-1:0]     rd_addr;
  logic [7:0]            rd_data;
  logic                  rd_ok;
  logic [SLOT_W-1:0]     emit_k;
  logic [INDEX_BITS-1:0] emit_pos;

  logic                  out_free;
  logic                  store_do;
  logic                  scan_take;
  logic                  one_fire;
  logic                  emit_fire;
  logic                  emit_last;
  result_t               result_next;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  assign exp_pos  = expected;
  assign ended    = ended_flag;
  assign idle     = (state == B_IDLE);
  assign out_free = !result_valid || !result_stall;
  assign emit_last = (emit_k == run_len);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          if (q_cmd.kind == CMD_DELIVER) begin
            state_next = q_cmd.final_byte ? B_COMMIT : B_SCAN;
          end else begin
            state_next = B_EMIT_ONE;
          end
        end
      end
      B_SCAN: begin
        if (!scan_take || final_mark[scan_slot]) begin
          state_next = B_COMMIT;
        end
      end
      B_COMMIT: begin
        state_next = B_EMIT_RUN;
      end
      B_EMIT_ONE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      B_EMIT_RUN: begin
        if (emit_fire && emit_last) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop     = 1'b0;
    store_do  = 1'b0;
    scan_take = 1'b0;
    one_fire  = 1'b0;
    emit_fire = 1'b0;
    unique case (state)
      B_IDLE: begin
        q_pop    = q_valid;
        store_do = q_valid && (q_cmd.kind == CMD_STORE) && !present[q_slot];
      end
      B_SCAN: begin
        scan_take = present[scan_slot] && (run_len != RUN_MAX);
      end
      B_EMIT_ONE: begin
        one_fire = out_free;
      end
      B_EMIT_RUN: begin
        emit_fire = out_free && ((emit_k == '0) || rd_ok);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_next.stream_ended  = ended_flag;
    result_next.pending_count = 7'(count);
    result_next.next_expected = 32'(expected);
    if (state == B_EMIT_RUN) begin
      result_next.out_valid    = 1'b1;
      result_next.out_byte     = (emit_k == '0) ? cmd_byte : rd_data;
      result_next.out_position = 32'(emit_pos);
      result_next.disposition  = DISP_DELIVERED;
      result_next.last_of_run  = emit_last;
    end else begin
      result_next.out_valid    = 1'b0;
      result_next.out_byte     = '0;
      result_next.out_position = '0;
      result_next.disposition  = disp_r;
      result_next.last_of_run  = 1'b1;
    end
  end

  // Byte store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (store_do) begin
      held_mem[q_slot] <= q_cmd.data_byte;
    end
    rd_data <= held_mem[rd_addr];
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_byte  <= q_cmd.data_byte;
      end_pend  <= q_cmd.final_byte;
      run_len   <= '0;
      scan_slot <= slot_inc(head);
      rd_addr   <= head;
      emit_k    <= '0;
      emit_pos  <= expected;
      if (q_cmd.kind == CMD_STORE) begin
        disp_r <= present[q_slot] ? DISP_DUPLICATE : DISP_BUFFERED;
      end else begin
        disp_r <= q_cmd.disp;
      end
    end
    if (scan_take) begin
      run_len   <= run_len + 1'b1;
      scan_slot <= slot_inc(scan_slot);
      if (final_mark[scan_slot]) begin
        end_pend <= 1'b1;
      end
    end
    if (emit_fire && !emit_last) begin
      emit_k   <= emit_k + 1'b1;
      emit_pos <= emit_pos + 1'b1;
      rd_addr  <= slot_inc(rd_addr);
    end
    if (one_fire || emit_fire) begin
      result <= result_next;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      expected     <= '0;
      head         <= '0;
      count        <= '0;
      ended_flag   <= 1'b0;
      present      <= '0;
      final_mark   <= '0;
      rd_ok        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_ok <= !(q_pop || emit_fire);
      if (store_do) begin
        present[q_slot]    <= 1'b1;
        final_mark[q_slot] <= q_cmd.final_byte;
        count              <= count + 1'b1;
      end
      if (scan_take) begin
        present[scan_slot]    <= 1'b0;
        final_mark[scan_slot] <= 1'b0;
      end
      if (state == B_COMMIT) begin
        expected   <= expected + INDEX_BITS'(run_len) + 1'b1;
        head       <= scan_slot;
        ended_flag <= end_pend;
        if (end_pend) begin
          count      <= '0;
          present    <= '0;
          final_mark <= '0;
        end else begin
          count <= count - run_len;
        end
      end
      if (one_fire || emit_fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> (int'(count) == $countones(present)))
    else $error("held count disagrees with the present bits");

  assert property (@(posedge clk) disable iff (rst)
    ended_flag |-> (present == '0))
    else $error("bytes still held after end of stream");

  assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> !present[head])
    else $error("slot of the expected index is marked present");

endmodule

// ----- hdl/tcp_stream_reassembler.sv -----
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   tsr_pkg::item_t
// result    out        result_valid / result_stall  tsr_pkg::result_t
// cfg       in         cfg_valid / cfg_ready     cfg_data, window size (7 bits)
//
// The front end issues a byte only once the back end is idle and the queue
// is empty. An in-order byte that releases held bytes is slowed by the
// one-slot-per-cycle run scan and by the registered read of the byte store
// for each released byte.
// Reset is synchronous and active high; it clears the expected index, the
// present and end marks, the held count and the end flag, and sets the
// window size back to 64.
// A stalled result stays in the output register while the front still
// takes one new input transfer.
module tcp_stream_reassembler #(
  parameter int WINDOW     = tsr_pkg::WINDOW_DEF,
  parameter int INDEX_BITS = tsr_pkg::INDEX_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  tsr_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output tsr_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [6:0]       cfg_data
);

  import tsr_pkg::*;

  // Slot index into the circular window store.
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int QW     = $bits(cmd_t) + SLOT_W;

  logic                  push;
  cmd_t                  push_cmd;
  logic [SLOT_W-1:0]     push_slot;
  logic                  q_valid;
  logic [QW-1:0]         q_data;
  cmd_t                  q_cmd;
  logic [SLOT_W-1:0]     q_slot;
  logic                  q_pop;
  logic [INDEX_BITS-1:0] exp_pos;
  logic [SLOT_W-1:0]     head;
  logic                  ended;
  logic                  back_idle;

  // Writes to the window register are only to be made while the block is idle;
  // the block does not enforce this itself, and no transfer is ever held off here.
  assign cfg_ready = 1'b1;

  // The front end holds one input item and classifies it against the
  // committed state: after end, in order, behind (a duplicate), beyond the
  // window, or a candidate for the store with its circular slot.
  tsr_front #(
    .WINDOW     (WINDOW),
    .INDEX_BITS (INDEX_BITS),
    .SLOT_W     (SLOT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .exp_pos    (exp_pos),
    .head       (head),
    .ended      (ended),
    .back_idle  (back_idle),
    .q_valid    (q_valid),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_slot  (push_slot)
  );

  // Classified commands wait here until the back end is free.
  tsr_cmd_queue #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_cmd, push_slot}),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  assign q_cmd  = q_data[QW-1:SLOT_W];
  assign q_slot = q_data[SLOT_W-1:0];

  // The back end owns the reassembly state. Stores check for a byte that
  // is already held; an in-order byte first scans the run of contiguous
  // held bytes so that every result of the run reports the state after the
  // whole step, then commits and drains the run through the output
  // register, one transfer per byte.
  tsr_back #(
    .WINDOW     (WINDOW),
    .INDEX_BITS (INDEX_BITS),
    .SLOT_W     (SLOT_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_slot       (q_slot),
    .q_pop        (q_pop),
    .exp_pos      (exp_pos),
    .head         (head),
    .ended        (ended),
    .idle         (back_idle),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- tb/tsr_checker.sv -----
// Watches the item, result and window-size channels of the reassembler,
// keeps its own copy of the reassembly state and checks every result transfer
// against the oldest predicted one.
module tsr_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  tsr_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  tsr_pkg::result_t result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [6:0]       cfg_data,
  output int               fail_count,
  output int               outstanding,
  output int               results_seen
);
  import tsr_pkg::*;

  localparam int DEPTH = 64;

  logic [31:0] next_pos;
  logic [7:0]  held_data [DEPTH];
  logic        held_valid [DEPTH];
  logic        held_last [DEPTH];
  logic [6:0]  held_total;
  logic        ended;
  logic [5:0]  head;
  logic [6:0]  win_setting;

  result_t pending_q[$];
  result_t step_q[$];
  result_t want;
  int      errors = 0;
  int      checked = 0;

  // One in-order byte leaves the store; the final byte closes the stream and
  // throws away whatever else is still held.
  task automatic emit_byte(input logic [7:0] val, input logic fin);
    result_t r;
    r = '0;
    r.out_valid = 1'b1;
    r.out_byte = val;
    r.out_position = next_pos;
    r.disposition = DISP_DELIVERED;
    step_q.push_back(r);
    held_valid[head] = 1'b0;
    held_last[head] = 1'b0;
    next_pos = next_pos + 32'd1;
    head = head + 6'd1;
    if (fin) begin
      ended = 1'b1;
      foreach (held_valid[i]) begin
        held_valid[i] = 1'b0;
        held_last[i] = 1'b0;
      end
      held_total = '0;
    end
  endtask

  task automatic emit_drop(input disp_t code);
    result_t r;
    r = '0;
    r.disposition = code;
    step_q.push_back(r);
  endtask

  task automatic predict_item(input item_t it);
    logic [31:0] ofs;
    logic [6:0]  span;
    logic [5:0]  slot;
    result_t     r;
    span = (win_setting == 0) ? 7'd1 : ((win_setting > DEPTH) ? 7'(DEPTH) : win_setting);
    ofs = it.stream_index - next_pos;
    step_q.delete();
    if (ended) begin
      emit_drop(DISP_AFTER_END);
    end else if (ofs == 0) begin
      emit_byte(it.data_byte, it.final_byte);
      while (!ended && held_valid[head] && step_q.size() < DEPTH) begin
        if (held_total != 0) held_total = held_total - 7'd1;
        emit_byte(held_data[head], held_last[head]);
      end
    end else if (ofs[31]) begin
      emit_drop(DISP_DUPLICATE);
    end else if (ofs >= {25'd0, span}) begin
      emit_drop(DISP_OUTSIDE);
    end else begin
      slot = head + ofs[5:0];
      if (held_valid[slot]) begin
        emit_drop(DISP_DUPLICATE);
      end else begin
        held_valid[slot] = 1'b1;
        held_data[slot] = it.data_byte;
        held_last[slot] = it.final_byte;
        held_total = held_total + 7'd1;
        emit_drop(DISP_BUFFERED);
      end
    end
    // Status fields show the state after the whole step on every result.
    foreach (step_q[k]) begin
      r = step_q[k];
      r.stream_ended = ended;
      r.pending_count = held_total;
      r.next_expected = next_pos;
      r.last_of_run = (k == step_q.size() - 1);
      pending_q.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: result field %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      next_pos = '0;
      foreach (held_valid[i]) begin
        held_valid[i] = 1'b0;
        held_last[i] = 1'b0;
        held_data[i] = '0;
      end
      held_total = '0;
      ended = 1'b0;
      head = '0;
      win_setting = WIN_RESET;
      pending_q.delete();
    end else begin
      // A result can never come from an item taken at the same edge, so the
      // result side is handled first.
      if (result_valid && !result_stall) begin
        checked++;
        if (pending_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got 0x%0h", $time, result);
          errors++;
        end else begin
          want = pending_q.pop_front();
          check_field("out_valid", 32'(want.out_valid), 32'(result.out_valid));
          check_field("out_byte", 32'(want.out_byte), 32'(result.out_byte));
          check_field("out_position", want.out_position, result.out_position);
          check_field("stream_ended", 32'(want.stream_ended), 32'(result.stream_ended));
          check_field("disposition", 32'(want.disposition), 32'(result.disposition));
          check_field("pending_count", 32'(want.pending_count),
                      32'(result.pending_count));
          check_field("next_expected", want.next_expected, result.next_expected);
          check_field("last_of_run", 32'(want.last_of_run), 32'(result.last_of_run));
        end
      end
      if (cfg_valid && cfg_ready) win_setting = cfg_data;
      if (item_valid && !item_stall) predict_item(item);
    end
    fail_count <= errors;
    outstanding <= pending_q.size();
    results_seen <= checked;
  end

endmodule

// ----- tb/tb.sv -----
// Top of the reassembler testbench. It drives byte transfers, window-size
// writes and the result-side stall pattern, and gives the verdict. All
// prediction and comparison lives in the checker instance beside the block.
module tb;
  import tsr_pkg::*;

  // The slowest legal run is far below this: roughly 470 items and the bytes
  // they drain, plus sender gaps, receiver stalls and one long hold-off.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 40;
  localparam int NUM_PHASES    = 8;
  localparam int HOLD_PHASE    = 5;

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [6:0] cfg_data;

  int fail_count;
  int outstanding;
  int results_seen;

  int items_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  // Stimulus-side view of the stream. Segments always cover a contiguous
  // range starting at the next expected index, so base plus the number of
  // leading positions already sent is exactly where the block stands.
  logic [31:0] base;
  int          lead;
  int          done_cnt;
  int          seg_len;
  int          perm [64];
  bit          sent [64];
  int          span;

  // Window settings per phase. The first phase runs on the reset value; the
  // others cover the smallest value, zero (treated as one), the largest code
  // (clamped to the store depth) and a few in between.
  int phase_win [NUM_PHASES] = '{64, 1, 0, 127, 9, 64, 2, 33};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tcp_stream_reassembler dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  tsr_checker chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tcp_stream_reassembler: mismatch");
      $finish;
    end
  end

  // Result-side stall pattern. It switches between segments with no stall at
  // all, light and heavy random stalling, and on request holds the output off
  // for a long stretch so that the block backs up and stalls its input.
  initial begin
    int mode;
    int len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(4, 40);
      repeat (len) begin
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= 1'($urandom_range(0, 1));
          default: result_stall <= ($urandom_range(0, 4) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offers one byte and waits for its transfer. The sender works in bursts:
  // when a burst is used up, it may drop valid for a random gap first. Valid
  // stays high between back-to-back bytes of a burst.
  task automatic send_byte(input logic [31:0] idx, input logic [7:0] val, input logic fin);
    item_t pkt;
    int    gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 5))
        0, 1, 2: gap = 0;
        3, 4: gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 25);
      endcase
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    pkt.stream_index = idx;
    pkt.data_byte = val;
    pkt.final_byte = fin;
    item <= pkt;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    burst_left--;
    items_sent++;
  endtask

  // Stops offering bytes until every predicted result has been seen, then
  // lets the block settle before anything is reconfigured.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [6:0] val);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A byte that must be dropped without touching the store: behind the
  // expected index anywhere in the lower half of the index space, just past
  // the window edge, far ahead, or a repeat of a position already sent in
  // the current segment. These may carry the final-byte flag freely.
  task automatic send_noise();
    logic [31:0] cur;
    logic [31:0] idx;
    cur = base + lead;
    case ($urandom_range(0, 3))
      0: idx = cur - $urandom_range(32'h8000_0000, 1);
      1: idx = cur + span + $urandom_range(0, 8);
      2: idx = cur + $urandom_range(32'h7FFF_FFFF, span);
      default: begin
        if (done_cnt > 0) idx = base + perm[$urandom_range(done_cnt - 1, 0)];
        else idx = cur - $urandom_range(4, 1);
      end
    endcase
    send_byte(idx, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Sends every position of one segment once, in order, shuffled, or
  // shuffled with its first position held back to the end so that the whole
  // segment drains in a single run. Noise is mixed in between.
  task automatic run_segment(input int forced_len, input bit gap_last_req);
    int j;
    int k;
    int tmp;
    int order;
    if (forced_len > 0) begin
      seg_len = forced_len;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: seg_len = $urandom_range(1, (span < 8) ? span : 8);
        7, 8: seg_len = $urandom_range(1, span);
        default: seg_len = span;
      endcase
    end
    for (j = 0; j < seg_len; j++) begin
      perm[j] = j;
      sent[j] = 1'b0;
    end
    order = gap_last_req ? 2 : $urandom_range(0, 2);
    if (order != 0) begin
      for (j = seg_len - 1; j > 0; j--) begin
        k = $urandom_range(0, j);
        tmp = perm[j];
        perm[j] = perm[k];
        perm[k] = tmp;
      end
    end
    if (order == 2) begin
      for (j = 0; j < seg_len; j++) begin
        if (perm[j] == 0) begin
          perm[j] = perm[seg_len - 1];
          perm[seg_len - 1] = 0;
        end
      end
    end
    lead = 0;
    done_cnt = 0;
    for (j = 0; j < seg_len; j++) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      send_byte(base + perm[j], 8'($urandom_range(0, 255)), 1'b0);
      sent[perm[j]] = 1'b1;
      done_cnt++;
      while (lead < seg_len && sent[lead]) lead++;
    end
    base = base + seg_len;
    lead = 0;
    done_cnt = 0;
  endtask

  initial begin
    int p;
    int quota;
    int j;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening on the reset window of 64.
    span = 64;
    base = '0;
    lead = 0;
    done_cnt = 0;
    send_byte(32'd0, 8'h00, 1'b0);           // in order at index zero
    send_byte(32'd3, 8'hFF, 1'b0);           // held ahead of the gap
    send_byte(32'd3, 8'h12, 1'b1);           // repeat of a held byte, first copy stays
    send_byte(32'd0, 8'h34, 1'b0);           // just behind
    send_byte(32'hFFFF_FFFF, 8'hFF, 1'b1);   // behind through the index wrap
    send_byte(32'h8000_0001, 8'h56, 1'b0);   // offset exactly half the index space
    send_byte(32'h8000_0000, 8'h78, 1'b1);   // largest forward offset, outside
    send_byte(32'd65, 8'h9A, 1'b0);          // first offset past the window
    send_byte(32'd64, 8'hA5, 1'b0);          // last slot of the window
    send_byte(32'd2, 8'h5A, 1'b0);
    send_byte(32'd1, 8'hC3, 1'b0);           // fills the gap, drains two held bytes
    base = 32'd4;

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_window(7'(phase_win[p]));
      end
      span = (phase_win[p] == 0) ? 1 : ((phase_win[p] > 64) ? 64 : phase_win[p]);
      // The first segment reaches the byte still held at index 64 and, with
      // its gap filled last, drains almost the whole store in one run.
      if (p == 0) run_segment(61, 1'b1);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else run_segment(0, 1'b0);
      end
    end

    // Close the stream: the final byte is held with bytes on both sides of
    // it, the gap is filled, the run stops at the final byte and the byte
    // held beyond it is discarded. Everything after that is refused.
    wait_drained();
    send_byte(base + 3, 8'($urandom_range(0, 255)), 1'b1);
    send_byte(base + 5, 8'($urandom_range(0, 255)), 1'b0);
    send_byte(base + 1, 8'($urandom_range(0, 255)), 1'b0);
    send_byte(base + 2, 8'($urandom_range(0, 255)), 1'b0);
    send_byte(base + 3, 8'($urandom_range(0, 255)), 1'b0);
    send_byte(base, 8'($urandom_range(0, 255)), 1'b0);
    send_byte(base + 4, 8'($urandom_range(0, 255)), 1'b0);
    for (j = 0; j < 15; j++) begin
      send_byte($urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    wait_drained();

    $display("Covered %0d byte transfers and %0d result transfers over %0d window settings,",
             items_sent, results_seen, NUM_PHASES);
    $display("with a %0d-cycle output hold-off, long drain runs and the end of the stream.",
             HOLD_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tcp_stream_reassembler: match");
    end else begin
      $display("tcp_stream_reassembler: mismatch");
    end
    $finish;
  end

endmodule
